// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top file
// no dependencies; define NO_ASSERTIONS to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/pecm_pkg.sv =====
// shared types, constants and tables of the pose to camera matrices block
// no dependencies; used by every module of the block
package pecm_pkg;

	localparam logic [17:0] FOV_MAX       = 18'd205887;
	localparam logic [13:0] IMG_SIZE_RST  = 14'd518;
	localparam logic [3:0]  REG_IMAGE_HEIGHT = 4'd0;
	localparam logic [3:0]  REG_IMAGE_WIDTH  = 4'd1;
	localparam logic [1:0]  ROW_INTRINSIC = 2'd3;
	localparam logic [31:0] SAT_POS       = 32'h7fff_ffff;
	localparam logic [4:0]  CORDIC_LAST   = 5'd29;
	localparam logic [4:0]  DIV_LAST      = 5'd30;

	// one pose after classification
	typedef struct packed {
		logic [2:0][31:0] trans;
		logic [3:0][31:0] mag;
		logic [3:0]       neg;
		logic [31:0]      mag_max;
		logic             zero;
		logic [1:0][17:0] fov;
	} pose_t;

	// queue head as seen by the engine
	typedef struct packed {
		logic  valid;
		pose_t pose;
	} q_stat_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [42:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_PROD,
		ST_DIV_SET,
		ST_DIV_RUN,
		ST_DOT,
		ST_DOT_END,
		ST_CORD,
		ST_FOC_MUL,
		ST_FOC_DIV,
		ST_DONE
	} eng_state_t;

	// arctangent of 2^-i in Q30
	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0: v = 30'd843314857;
			5'd1: v = 30'd497837829;
			5'd2: v = 30'd263043837;
			5'd3: v = 30'd133525159;
			5'd4: v = 30'd67021687;
			5'd5: v = 30'd33543516;
			5'd6: v = 30'd16775851;
			5'd7: v = 30'd8388437;
			5'd8: v = 30'd4194283;
			5'd9: v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			5'd24: v = 30'd64;
			5'd25: v = 30'd32;
			5'd26: v = 30'd16;
			5'd27: v = 30'd8;
			5'd28: v = 30'd4;
			5'd29: v = 30'd2;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/pecm_ifs.sv =====
// channel interfaces of the pose to camera matrices block
// no dependencies
interface pecm_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] trans_x;
	logic signed [31:0] trans_y;
	logic signed [31:0] trans_z;
	logic signed [31:0] quat_w;
	logic signed [31:0] quat_x;
	logic signed [31:0] quat_y;
	logic signed [31:0] quat_z;
	logic [17:0]        fov_horiz;
	logic [17:0]        fov_vert;
	modport source(output valid, trans_x, trans_y, trans_z, quat_w, quat_x, quat_y, quat_z,
		fov_horiz, fov_vert, input ready);
	modport sink(input valid, trans_x, trans_y, trans_z, quat_w, quat_x, quat_y, quat_z,
		fov_horiz, fov_vert, output ready);
endinterface

interface pecm_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         row_kind;
	logic signed [31:0] value_a;
	logic signed [31:0] value_b;
	logic signed [31:0] value_c;
	logic signed [31:0] value_d;
	logic               last_item;
	modport source(output valid, row_kind, value_a, value_b, value_c, value_d, last_item,
		input ready);
	modport sink(input valid, row_kind, value_a, value_b, value_c, value_d, last_item,
		output ready);
endinterface

interface pecm_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/pecm_front.sv =====
// front end: accepts poses, classifies the quaternion and fov, queues them
// depends on pecm_pkg and pecm_ifs
module pecm_front (
	input  logic              clk,
	input  logic              arst_n,
	pecm_pose_if.sink         pose,
	input  logic              pop,
	output pecm_pkg::q_stat_t q_stat
);
	import pecm_pkg::*;

	pose_t       ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	pose_t       cls;
	logic [31:0] qv [4];
	logic [31:0] max01;
	logic [31:0] max23;

	assign qv[0] = pose.quat_w;
	assign qv[1] = pose.quat_x;
	assign qv[2] = pose.quat_y;
	assign qv[3] = pose.quat_z;

	// classification: sign, magnitude, largest part, clamped angles
	always_comb begin
		cls.trans[0] = pose.trans_x;
		cls.trans[1] = pose.trans_y;
		cls.trans[2] = pose.trans_z;
		for (int i = 0; i < 4; i++) begin
			cls.neg[i] = qv[i][31];
			cls.mag[i] = qv[i][31] ? (~qv[i] + 32'd1) : qv[i];
		end
		max01 = (cls.mag[0] > cls.mag[1]) ? cls.mag[0] : cls.mag[1];
		max23 = (cls.mag[2] > cls.mag[3]) ? cls.mag[2] : cls.mag[3];
		cls.mag_max = (max01 > max23) ? max01 : max23;
		cls.zero = (cls.mag_max == 32'd0);
		cls.fov[0] = (pose.fov_horiz > FOV_MAX) ? FOV_MAX : pose.fov_horiz;
		cls.fov[1] = (pose.fov_vert > FOV_MAX) ? FOV_MAX : pose.fov_vert;
	end

	assign pose.ready = (cnt_q != 2'd2);
	assign push = pose.valid && pose.ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign q_stat.valid = (cnt_q != 2'd0);
	assign q_stat.pose  = ent_q[rd_ptr_q];

endmodule

// ===== rtl/pecm_div.sv =====
// shared restoring divider, one quotient bit per cycle, 31 bits, saturating
// depends on pecm_pkg
module pecm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pecm_pkg::div_req_t req,
	output pecm_pkg::div_rsp_t rsp
);
	import pecm_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  stp_q;
	logic        sat_q;
	logic [42:0] rem_q;
	logic [30:0] lo_q;
	logic [30:0] quo_q;
	logic [42:0] dvs_q;
	logic [42:0] hi_c;
	logic [43:0] trial;
	logic        fits;

	assign hi_c  = {10'd0, req.dividend[63:31]};
	assign trial = {rem_q, lo_q[30]};
	assign fits  = (trial >= {1'b0, dvs_q});

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			stp_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				stp_q  <= 5'd0;
			end else if (busy_q) begin
				stp_q <= stp_q + 5'd1;
				if (stp_q == DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			sat_q <= (hi_c >= req.divisor);
			rem_q <= (hi_c >= req.divisor) ? 43'd0 : hi_c;
			lo_q  <= req.dividend[30:0];
			dvs_q <= req.divisor;
			quo_q <= 31'd0;
		end else if (busy_q) begin
			rem_q <= fits ? 43'(trial - {1'b0, dvs_q}) : trial[42:0];
			quo_q <= {quo_q[29:0], fits};
			lo_q  <= {lo_q[29:0], 1'b0};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = sat_q ? SAT_POS : {1'b0, quo_q};

endmodule

// ===== rtl/pecm_engine.sv =====
// back end: rotation, extrinsic rows, cordic focal lengths and result buffer
// depends on pecm_pkg and pecm_ifs; drives the shared divider pecm_div through its ports
module pecm_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  pecm_pkg::q_stat_t  q_stat,
	output logic               pop,
	output pecm_pkg::div_req_t div_req,
	input  pecm_pkg::div_rsp_t div_rsp,
	input  logic [13:0]        image_height,
	input  logic [13:0]        image_width,
	pecm_result_if.source      result
);
	import pecm_pkg::*;

	eng_state_t state_q, state_d;
	logic [3:0] cnt_q;
	logic       ph_q;
	logic [1:0] row_q;
	logic       sel_q;
	logic [4:0] it_q;
	logic       ob_full_q;
	logic [1:0] ecnt_q;

	logic signed [31:0] t_q [3];
	logic [31:0]        mag_q [4];
	logic               neg_q [4];
	logic [31:0]        m_q;
	logic [17:0]        fov_q [2];
	logic signed [30:0] s_q [4];
	logic signed [61:0] pr_q [10];
	logic [63:0]        n_q;
	logic signed [19:0] r_q [9];
	logic               rneg_q;
	logic signed [51:0] acc_q;
	logic signed [31:0] d_q [3];
	logic [31:0]        f_q [2];
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [65:0] mul_q;
	logic signed [31:0] ob_q [4][4];

	logic signed [32:0] op_a, op_b;
	logic signed [62:0] pe [10];
	logic signed [62:0] num_c;
	logic [62:0]        num_mag;
	logic [3:0]         ridx;
	logic               norm_ok;
	logic               y_le0;
	logic signed [33:0] xs, ys, at;
	logic signed [19:0] rv;
	logic signed [52:0] nacc;
	logic signed [36:0] rsh;
	logic signed [31:0] d_c;
	logic [13:0]        size_c;
	logic [17:0]        fov_nx;

	for (genvar g = 0; g < 10; g++) begin : g_pe
		assign pe[g] = {pr_q[g][61], pr_q[g]};
	end

	assign norm_ok = (m_q[31:30] == 2'b00) && m_q[29];
	assign y_le0   = y_q[33] || (y_q == 34'sd0);
	assign xs      = x_q >>> it_q;
	assign ys      = y_q >>> it_q;
	assign at      = $signed({4'd0, atan_q30(it_q)});
	assign size_c  = sel_q ? image_height : image_width;
	assign fov_nx  = fov_q[1];
	assign rv      = rneg_q ? -$signed(div_rsp.quotient[19:0])
		: $signed(div_rsp.quotient[19:0]);

	// numerator of the current rotation term
	always_comb begin
		case (cnt_q)
			4'd0: num_c = pe[2] + pe[3];
			4'd1: num_c = pe[4] - pe[9];
			4'd2: num_c = pe[5] + pe[8];
			4'd3: num_c = pe[4] + pe[9];
			4'd4: num_c = pe[1] + pe[3];
			4'd5: num_c = pe[6] - pe[7];
			4'd6: num_c = pe[5] - pe[8];
			4'd7: num_c = pe[6] + pe[7];
			4'd8: num_c = pe[1] + pe[2];
			default: num_c = 63'sd0;
		endcase
		num_mag = num_c[62] ? 63'(-num_c) : 63'(num_c);
	end

	// negated dot product rounded to q16.16 and saturated
	always_comb begin
		nacc = -{acc_q[51], acc_q} + 53'sd32768;
		rsh  = nacc[52:16];
		if (rsh > 37'sd2147483647) begin
			d_c = 32'sh7fff_ffff;
		end else if (rsh < -37'sd2147483648) begin
			d_c = -32'sh8000_0000;
		end else begin
			d_c = rsh[31:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_stat.valid) begin
					state_d = q_stat.pose.zero ? ST_DOT : ST_NORM;
				end
			end
			ST_NORM: begin
				if (norm_ok) begin
					state_d = ST_PROD;
				end
			end
			ST_PROD: begin
				if (ph_q && cnt_q == 4'd9) begin
					state_d = ST_DIV_SET;
				end
			end
			ST_DIV_SET: state_d = ST_DIV_RUN;
			ST_DIV_RUN: begin
				if (div_rsp.done) begin
					state_d = (cnt_q == 4'd8) ? ST_DOT : ST_DIV_SET;
				end
			end
			ST_DOT: begin
				if (ph_q && cnt_q == 4'd2) begin
					state_d = ST_DOT_END;
				end
			end
			ST_DOT_END: state_d = (row_q == 2'd2) ? ST_CORD : ST_DOT;
			ST_CORD: begin
				if (it_q == CORDIC_LAST) begin
					state_d = ST_FOC_MUL;
				end
			end
			ST_FOC_MUL: begin
				if (ph_q) begin
					state_d = ST_FOC_DIV;
				end else if (y_le0) begin
					state_d = sel_q ? ST_DONE : ST_CORD;
				end
			end
			ST_FOC_DIV: begin
				if (div_rsp.done) begin
					state_d = sel_q ? ST_DONE : ST_CORD;
				end
			end
			ST_DONE: begin
				if (!ob_full_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: queue pop, divider request, multiplier operands
	always_comb begin
		pop              = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = {4'd0, num_mag[62:20], 17'd0} + {22'd0, n_q[62:21]};
		div_req.divisor  = n_q[62:20];
		op_a             = 33'sd0;
		op_b             = 33'sd0;
		ridx             = {2'd0, row_q} + ((cnt_q == 4'd0) ? 4'd0
			: (cnt_q == 4'd1) ? 4'd3 : 4'd6);
		case (state_q)
			ST_IDLE: pop = q_stat.valid;
			ST_PROD: begin
				case (cnt_q)
					4'd0: begin op_a = {{2{s_q[0][30]}}, s_q[0]}; op_b = {{2{s_q[0][30]}}, s_q[0]}; end
					4'd1: begin op_a = {{2{s_q[1][30]}}, s_q[1]}; op_b = {{2{s_q[1][30]}}, s_q[1]}; end
					4'd2: begin op_a = {{2{s_q[2][30]}}, s_q[2]}; op_b = {{2{s_q[2][30]}}, s_q[2]}; end
					4'd3: begin op_a = {{2{s_q[3][30]}}, s_q[3]}; op_b = {{2{s_q[3][30]}}, s_q[3]}; end
					4'd4: begin op_a = {{2{s_q[1][30]}}, s_q[1]}; op_b = {{2{s_q[2][30]}}, s_q[2]}; end
					4'd5: begin op_a = {{2{s_q[1][30]}}, s_q[1]}; op_b = {{2{s_q[3][30]}}, s_q[3]}; end
					4'd6: begin op_a = {{2{s_q[2][30]}}, s_q[2]}; op_b = {{2{s_q[3][30]}}, s_q[3]}; end
					4'd7: begin op_a = {{2{s_q[1][30]}}, s_q[1]}; op_b = {{2{s_q[0][30]}}, s_q[0]}; end
					4'd8: begin op_a = {{2{s_q[2][30]}}, s_q[2]}; op_b = {{2{s_q[0][30]}}, s_q[0]}; end
					4'd9: begin op_a = {{2{s_q[3][30]}}, s_q[3]}; op_b = {{2{s_q[0][30]}}, s_q[0]}; end
					default: begin op_a = 33'sd0; op_b = 33'sd0; end
				endcase
			end
			ST_DIV_SET: div_req.start = 1'b1;
			ST_DOT: begin
				op_a = {{13{r_q[ridx][19]}}, r_q[ridx]};
				op_b = {t_q[cnt_q[1:0]][31], t_q[cnt_q[1:0]]};
			end
			ST_FOC_MUL: begin
				op_a = $signed({4'd0, size_c, 15'd0});
				op_b = x_q[33] ? 33'sd0 : x_q[32:0];
				if (ph_q) begin
					div_req.start    = 1'b1;
					div_req.dividend = mul_q[63:0] + {31'd0, y_q[33:1]};
					div_req.divisor  = {9'd0, y_q};
				end
			end
			default: ;
		endcase
	end

	// sequencer counters and result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= 4'd0;
			ph_q      <= 1'b0;
			row_q     <= 2'd0;
			sel_q     <= 1'b0;
			it_q      <= 5'd0;
			ob_full_q <= 1'b0;
			ecnt_q    <= 2'd0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= 4'd0;
					ph_q  <= 1'b0;
					row_q <= 2'd0;
				end
				ST_PROD: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						cnt_q <= (cnt_q == 4'd9) ? 4'd0 : cnt_q + 4'd1;
					end
				end
				ST_DIV_RUN: begin
					if (div_rsp.done) begin
						cnt_q <= (cnt_q == 4'd8) ? 4'd0 : cnt_q + 4'd1;
						ph_q  <= 1'b0;
						row_q <= 2'd0;
					end
				end
				ST_DOT: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						cnt_q <= (cnt_q == 4'd2) ? 4'd0 : cnt_q + 4'd1;
					end
				end
				ST_DOT_END: begin
					row_q <= row_q + 2'd1;
					sel_q <= 1'b0;
					it_q  <= 5'd0;
				end
				ST_CORD: it_q <= it_q + 5'd1;
				ST_FOC_MUL: begin
					if (ph_q) begin
						ph_q <= 1'b0;
					end else if (y_le0) begin
						sel_q <= 1'b1;
						it_q  <= 5'd0;
					end else begin
						ph_q <= 1'b1;
					end
				end
				ST_FOC_DIV: begin
					if (div_rsp.done) begin
						sel_q <= 1'b1;
						it_q  <= 5'd0;
					end
				end
				default: ;
			endcase
			// result buffer: filled at the end of a pose, drained one transfer at a time
			if (state_q == ST_DONE && !ob_full_q) begin
				ob_full_q <= 1'b1;
				ecnt_q    <= 2'd0;
			end else if (result.valid && result.ready) begin
				ecnt_q <= ecnt_q + 2'd1;
				if (ecnt_q == ROW_INTRINSIC) begin
					ob_full_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		mul_q <= op_a * op_b;
		case (state_q)
			ST_IDLE: begin
				if (q_stat.valid) begin
					for (int i = 0; i < 3; i++) begin
						t_q[i] <= $signed(q_stat.pose.trans[i]);
					end
					for (int i = 0; i < 4; i++) begin
						mag_q[i] <= q_stat.pose.mag[i];
						neg_q[i] <= q_stat.pose.neg[i];
					end
					m_q      <= q_stat.pose.mag_max;
					fov_q[0] <= q_stat.pose.fov[0];
					fov_q[1] <= q_stat.pose.fov[1];
					for (int i = 0; i < 9; i++) begin
						r_q[i] <= (i == 0 || i == 4 || i == 8) ? 20'sd65536 : 20'sd0;
					end
				end
			end
			ST_NORM: begin
				if (m_q[31:30] != 2'b00) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < 4; i++) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end else if (!m_q[29]) begin
					m_q <= m_q << 1;
					for (int i = 0; i < 4; i++) begin
						mag_q[i] <= mag_q[i] << 1;
					end
				end else begin
					for (int i = 0; i < 4; i++) begin
						s_q[i] <= neg_q[i] ? -$signed(mag_q[i][30:0]) : $signed(mag_q[i][30:0]);
					end
				end
			end
			ST_PROD: begin
				if (ph_q) begin
					pr_q[cnt_q] <= mul_q[61:0];
					if (cnt_q == 4'd9) begin
						n_q <= {2'd0, pr_q[0]} + {2'd0, pr_q[1]} + {2'd0, pr_q[2]}
							+ {2'd0, pr_q[3]};
					end
				end
			end
			ST_DIV_SET: rneg_q <= num_c[62];
			ST_DIV_RUN: begin
				if (div_rsp.done) begin
					if (cnt_q == 4'd0 || cnt_q == 4'd4 || cnt_q == 4'd8) begin
						r_q[cnt_q] <= 20'sd65536 - rv;
					end else begin
						r_q[cnt_q] <= rv;
					end
				end
			end
			ST_DOT: begin
				if (ph_q) begin
					acc_q <= ((cnt_q == 4'd0) ? 52'sd0 : acc_q) + mul_q[51:0];
				end
			end
			ST_DOT_END: begin
				d_q[row_q] <= d_c;
				x_q <= 34'sd1 <<< 30;
				y_q <= 34'sd0;
				z_q <= $signed({3'd0, fov_q[0], 13'd0});
			end
			ST_CORD: begin
				if (!z_q[33]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
			end
			ST_FOC_MUL: begin
				if (!ph_q && y_le0) begin
					f_q[sel_q] <= SAT_POS;
					x_q <= 34'sd1 <<< 30;
					y_q <= 34'sd0;
					z_q <= $signed({3'd0, fov_nx, 13'd0});
				end
			end
			ST_FOC_DIV: begin
				if (div_rsp.done) begin
					f_q[sel_q] <= div_rsp.quotient;
					x_q <= 34'sd1 <<< 30;
					y_q <= 34'sd0;
					z_q <= $signed({3'd0, fov_nx, 13'd0});
				end
			end
			ST_DONE: begin
				if (!ob_full_q) begin
					for (int r = 0; r < 3; r++) begin
						ob_q[r][0] <= {{12{r_q[r][19]}}, r_q[r]};
						ob_q[r][1] <= {{12{r_q[r + 3][19]}}, r_q[r + 3]};
						ob_q[r][2] <= {{12{r_q[r + 6][19]}}, r_q[r + 6]};
						ob_q[r][3] <= d_q[r];
					end
					ob_q[3][0] <= $signed(f_q[0]);
					ob_q[3][1] <= $signed(f_q[1]);
					ob_q[3][2] <= $signed({3'd0, image_width, 15'd0});
					ob_q[3][3] <= $signed({3'd0, image_height, 15'd0});
				end
			end
			default: ;
		endcase
	end

	assign result.valid     = ob_full_q;
	assign result.row_kind  = ecnt_q;
	assign result.value_a   = ob_q[ecnt_q][0];
	assign result.value_b   = ob_q[ecnt_q][1];
	assign result.value_c   = ob_q[ecnt_q][2];
	assign result.value_d   = ob_q[ecnt_q][3];
	assign result.last_item = (ecnt_q == ROW_INTRINSIC);

endmodule

// ===== rtl/pose_encoding_to_camera_matrices_top.sv =====
// Pose encoding to camera matrices.
// Channel pose takes one camera pose (translation, quaternion, two fov angles)
// per transfer. Channel result returns four items per pose: extrinsic rows
// 0, 1 and 2 as [R^T | -R^T t], then the intrinsic item fx, fy, cx, cy with
// last_item set. All values are Q16.16. Channel cfg writes image_height
// (index 0) and image_width (index 1); other indexes are ignored, and cfg is
// always ready. Write it only while no pose is in flight.
// Each pose uses the shared 31-step restoring divider (nine rotation terms
// and two focal lengths) and the shared 30-step cordic run once per fov;
// a zero quaternion skips the divider for the rotation.
// A two-entry queue holds poses ahead of the engine, and a four-item result
// buffer lets the engine start the next pose while results wait.
// When the receiver stalls the buffer holds its item; the engine stops only
// when it finishes a pose with the buffer still full.
// Reset clears queue, sequencer and buffer and sets both image sizes to 518.
// depends on pecm_pkg, pecm_ifs, pecm_front, pecm_div, pecm_engine
`include "assert_macros.svh"
module pose_encoding_to_camera_matrices_top (
	input  logic          clk,
	input  logic          arst_n,
	pecm_pose_if.sink     pose,
	pecm_result_if.source result,
	pecm_cfg_if.sink      cfg
);
	import pecm_pkg::*;

	q_stat_t     q_stat;
	logic        q_pop;
	div_req_t    div_req;
	div_rsp_t    div_rsp;
	logic [13:0] image_height_q;
	logic [13:0] image_width_q;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_height_q <= IMG_SIZE_RST;
			image_width_q  <= IMG_SIZE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_IMAGE_HEIGHT: image_height_q <= cfg.data[13:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg.data[13:0];
				default: ;
			endcase
		end
	end

	pecm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pose   (pose),
		.pop    (q_pop),
		.q_stat (q_stat)
	);

	pecm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	pecm_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.pop          (q_pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.image_height (image_height_q),
		.image_width  (image_width_q),
		.result       (result)
	);

	// checks
	`ASSERT_CLK(a_pop_has_entry, clk, arst_n, q_pop |-> q_stat.valid)
	`ASSERT_NEVER(a_div_start_busy, clk, arst_n, div_req.start && div_rsp.busy)
	`ASSERT_CLK(a_last_on_intrinsic, clk, arst_n, result.valid |-> (result.last_item == (result.row_kind == ROW_INTRINSIC)))

endmodule

// ===== tb/sv/pecm_matrix_checker.sv =====
`timescale 1ns / 1ps
// checker for the pose to camera matrices block: watches pose, cfg and result
// channels, predicts the four result items of each pose and compares them
// depends on pecm_pkg and pecm_ifs
module pecm_matrix_checker (
	input  logic   clk,
	input  logic   arst_n,
	pecm_pose_if   pose,
	pecm_result_if result,
	pecm_cfg_if    cfg,
	output int     errors,
	output int     pending
);
	import pecm_pkg::*;

	localparam longint FOV_CLAMP = 205887;
	localparam longint Q_ONE = 65536;

	typedef struct packed {
		logic [1:0]  row_kind;
		logic [31:0] value_a;
		logic [31:0] value_b;
		logic [31:0] value_c;
		logic [31:0] value_d;
		logic        last_item;
	} matrix_row_t;

	longint angle_tab [30] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2
	};

	matrix_row_t expected_rows [$];
	logic [13:0] img_height;
	logic [13:0] img_width;

	assign pending = expected_rows.size();

	// 2*num/den rounded, sign of num
	function automatic longint rot_term(input longint num, input longint unsigned den);
		longint unsigned mag, a, b, r;
		mag = (num < 0) ? longint'(-num) : num;
		a = mag >> 20;
		b = den >> 20;
		r = ((a << 17) + (b >> 1)) / b;
		return (num < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// cordic tan and focal length
	function automatic longint focal_len(input logic [13:0] size, input logic [17:0] fov_in);
		longint x, y, z, xs, ys, fv;
		longint unsigned num, q;
		x = 64'sd1 << 30;
		y = 0;
		fv = longint'(fov_in);
		if (fv > FOV_CLAMP) fv = FOV_CLAMP;
		z = fv << 13;
		for (int i = 0; i < 30; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - angle_tab[i];
			end else begin
				x = x + ys; y = y - xs; z = z + angle_tab[i];
			end
		end
		if (x < 0) x = 0;
		if (y <= 0) return 64'sd2147483647;
		num = (longint'(size) << 15) * x;
		q = (num + (longint'(y) >> 1)) / longint'(y);
		if (q > 64'd2147483647) q = 64'd2147483647;
		return longint'(q);
	endfunction

	// rotation, extrinsic rows and intrinsic item of one pose
	task automatic predict_matrices(input logic [2:0][31:0] t_in,
			input logic [3:0][31:0] q_in, input logic [17:0] fovh, input logic [17:0] fovv);
		longint t [3];
		longint s [4];
		longint rm [9];
		longint unsigned mg [4];
		longint unsigned m, n;
		logic ng [4];
		longint w, x, y, z, dot;
		matrix_row_t row;
		m = 0;
		for (int i = 0; i < 3; i++) t[i] = longint'($signed(t_in[i]));
		for (int i = 0; i < 4; i++) begin
			s[i] = longint'($signed(q_in[i]));
			ng[i] = s[i] < 0;
			mg[i] = ng[i] ? -s[i] : s[i];
			if (mg[i] > m) m = mg[i];
		end
		if (m == 0) begin
			// zero quaternion gives identity
			for (int i = 0; i < 9; i++) rm[i] = 0;
			rm[0] = Q_ONE; rm[4] = Q_ONE; rm[8] = Q_ONE;
		end else begin
			// scale so the largest part lies in [2^29, 2^30)
			while (m >= (64'd1 << 30)) begin
				m = m >> 1;
				for (int i = 0; i < 4; i++) mg[i] = mg[i] >> 1;
			end
			while (m < (64'd1 << 29)) begin
				m = m << 1;
				for (int i = 0; i < 4; i++) mg[i] = mg[i] << 1;
			end
			for (int i = 0; i < 4; i++) s[i] = ng[i] ? -longint'(mg[i]) : longint'(mg[i]);
			w = s[0]; x = s[1]; y = s[2]; z = s[3];
			n = w * w + x * x + y * y + z * z;
			rm[0] = Q_ONE - rot_term(y * y + z * z, n);
			rm[1] = rot_term(x * y - z * w, n);
			rm[2] = rot_term(x * z + y * w, n);
			rm[3] = rot_term(x * y + z * w, n);
			rm[4] = Q_ONE - rot_term(x * x + z * z, n);
			rm[5] = rot_term(y * z - x * w, n);
			rm[6] = rot_term(x * z - y * w, n);
			rm[7] = rot_term(y * z + x * w, n);
			rm[8] = Q_ONE - rot_term(x * x + y * y, n);
		end
		// rows of R^T with negated, rounded translation
		for (int i = 0; i < 3; i++) begin
			dot = rm[i] * t[0] + rm[3 + i] * t[1] + rm[6 + i] * t[2];
			row.row_kind = i[1:0];
			row.value_a = rm[i][31:0];
			row.value_b = rm[3 + i][31:0];
			row.value_c = rm[6 + i][31:0];
			row.value_d = 32'(clip32((32768 - dot) >>> 16));
			row.last_item = 1'b0;
			expected_rows.push_back(row);
		end
		row.row_kind = ROW_INTRINSIC;
		row.value_a = 32'(focal_len(img_width, fovh));
		row.value_b = 32'(focal_len(img_height, fovv));
		row.value_c = {3'b0, img_width, 15'b0};
		row.value_d = {3'b0, img_height, 15'b0};
		row.last_item = 1'b1;
		expected_rows.push_back(row);
	endtask

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	initial errors = 0;

	// watch transfers on all three channels
	always @(posedge clk or negedge arst_n) begin
		matrix_row_t exp_row;
		if (!arst_n) begin
			img_height <= IMG_SIZE_RST;
			img_width <= IMG_SIZE_RST;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_IMAGE_HEIGHT) img_height <= cfg.data[13:0];
				else if (cfg.index == REG_IMAGE_WIDTH) img_width <= cfg.data[13:0];
			end
			if (pose.valid && pose.ready)
				predict_matrices({pose.trans_z, pose.trans_y, pose.trans_x},
					{pose.quat_z, pose.quat_y, pose.quat_x, pose.quat_w},
					pose.fov_horiz, pose.fov_vert);
			if (result.valid && result.ready) begin
				if (expected_rows.size() == 0) begin
					report("result transfer with nothing expected");
				end else begin
					exp_row = expected_rows.pop_front();
					if (result.row_kind !== exp_row.row_kind)
						report($sformatf("row_kind %0d exp %0d", result.row_kind,
							exp_row.row_kind));
					if (result.value_a !== exp_row.value_a)
						report($sformatf("kind %0d value_a %h exp %h", exp_row.row_kind,
							result.value_a, exp_row.value_a));
					if (result.value_b !== exp_row.value_b)
						report($sformatf("kind %0d value_b %h exp %h", exp_row.row_kind,
							result.value_b, exp_row.value_b));
					if (result.value_c !== exp_row.value_c)
						report($sformatf("kind %0d value_c %h exp %h", exp_row.row_kind,
							result.value_c, exp_row.value_c));
					if (result.value_d !== exp_row.value_d)
						report($sformatf("kind %0d value_d %h exp %h", exp_row.row_kind,
							result.value_d, exp_row.value_d));
					if (result.last_item !== exp_row.last_item)
						report($sformatf("kind %0d last_item %b exp %b", exp_row.row_kind,
							result.last_item, exp_row.last_item));
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// top of the pose to camera matrices testbench: clock, reset, stimulus, verdict
// depends on pecm_pkg, pecm_ifs, the block and pecm_matrix_checker
module tb_top;
	import pecm_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_POSES = 200;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   cycles;
	int   tx_idle;
	int   rx_idle;
	logic rx_hold;

	pecm_pose_if   pose ();
	pecm_result_if result ();
	pecm_cfg_if    cfg ();

	pose_encoding_to_camera_matrices_top dut (
		.clk(clk), .arst_n(arst_n), .pose(pose), .result(result), .cfg(cfg)
	);

	pecm_matrix_checker checker_i (
		.clk(clk), .arst_n(arst_n), .pose(pose), .result(result), .cfg(cfg),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// cycle limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("pose_encoding_to_camera_matrices_top regression: fail");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk)
		result.ready <= !rx_hold && ($urandom_range(99) >= rx_idle);

	task automatic send_pose(input logic [31:0] tx, input logic [31:0] ty,
			input logic [31:0] tz, input logic [31:0] qw, input logic [31:0] qx,
			input logic [31:0] qy, input logic [31:0] qz, input logic [17:0] fh,
			input logic [17:0] fv);
		while ($urandom_range(99) < tx_idle) begin
			@(negedge clk);
			pose.valid <= 1'b0;
		end
		@(negedge clk);
		pose.valid <= 1'b1;
		pose.trans_x <= tx; pose.trans_y <= ty; pose.trans_z <= tz;
		pose.quat_w <= qw; pose.quat_x <= qx; pose.quat_y <= qy; pose.quat_z <= qz;
		pose.fov_horiz <= fh; pose.fov_vert <= fv;
		do @(posedge clk); while (!pose.ready);
	endtask

	task automatic drain;
		@(negedge clk);
		pose.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// random quaternion part: full range, small, or zero
	function automatic logic [31:0] rand_quat();
		int pick;
		pick = $urandom_range(9);
		if (pick < 4) return $urandom;
		if (pick < 9) return $signed($urandom) >>> $urandom_range(31);
		return 32'd0;
	endfunction

	function automatic logic [17:0] rand_fov();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) return 18'($urandom);
		if (pick == 1) return 18'($urandom_range(40));
		return 18'($urandom_range(FOV_MAX));
	endfunction

	task automatic random_poses(input int count);
		logic [31:0] q0, q1, q2, q3;
		for (int i = 0; i < count; i++) begin
			q0 = rand_quat(); q1 = rand_quat(); q2 = rand_quat(); q3 = rand_quat();
			if ($urandom_range(19) == 0) begin
				q0 = 0; q1 = 0; q2 = 0; q3 = 0;
			end
			send_pose($urandom, $urandom, $urandom, q0, q1, q2, q3, rand_fov(), rand_fov());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx_hold = 1'b0;
		tx_idle = 0;
		rx_idle = 0;
		pose.valid = 1'b0;
		pose.trans_x = 0; pose.trans_y = 0; pose.trans_z = 0;
		pose.quat_w = 0; pose.quat_x = 0; pose.quat_y = 0; pose.quat_z = 0;
		pose.fov_horiz = 0; pose.fov_vert = 0;
		cfg.valid = 1'b0;
		cfg.index = REG_IMAGE_HEIGHT;
		cfg.data = 0;
		result.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed poses at reset sizes
		send_pose(0, 0, 0, 0, 0, 0, 0, 18'd102944, 18'd102944);
		send_pose(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0, FOV_MAX);
		send_pose(32'h00010000, 32'h00020000, 32'hfffd0000, 32'h00010000, 0, 0, 0,
			18'd1, 18'd2);
		send_pose(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 18'h3ffff, 18'd205888);
		send_pose(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, FOV_MAX, 0);
		send_pose(32'h12345678, 32'hdeadbeef, 32'h00000001, 0, 32'h00000001, 0, 0,
			18'd65536, 18'd30000);
		send_pose(32'hffffffff, 32'h00000001, 32'h40000000, 0, 0, 32'hffffffff, 0,
			18'd100, 18'd200000);
		send_pose(32'h00008000, 32'hffff8000, 32'h00004000, 0, 0, 0, 32'h7fffffff,
			18'd205000, 18'd3);
		send_pose(32'h7fff0000, 32'h80010000, 32'h0, 32'h00000001, 32'h00000001,
			32'h00000001, 32'h00000001, 18'd51472, 18'd154415);
		send_pose(32'h55555555, 32'haaaaaaaa, 32'h33333333, 32'hc0000000, 32'h40000000,
			32'hffff0000, 32'h00000003, 18'h2aaaa, 18'h15555);
		drain();

		// extreme sizes, zero size and two ignored indexes
		write_reg(REG_IMAGE_HEIGHT, 16'd1);
		write_reg(REG_IMAGE_WIDTH, 16'd8192);
		send_pose(32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000, 0, 0, 0,
			18'd1, 18'd102944);
		send_pose(0, 0, 0, 0, 0, 0, 0, FOV_MAX, 18'd10);
		drain();
		write_reg(REG_IMAGE_HEIGHT, 16'hffff);
		write_reg(REG_IMAGE_WIDTH, 16'd0);
		write_reg(4'd2, 16'd77);
		write_reg(4'hf, 16'd99);
		send_pose(32'h00010000, 0, 0, 0, 0, 0, 32'h00010000, 18'd102944, 18'd5);
		send_pose(0, 0, 0, 0, 0, 0, 0, 0, 0);
		drain();

		// sender idles more rarely than the receiver
		write_reg(REG_IMAGE_HEIGHT, 16'd518);
		write_reg(REG_IMAGE_WIDTH, 16'($urandom));
		tx_idle = 27;
		rx_idle = 77;
		random_poses(RANDOM_POSES / 3);
		drain();

		// and the other way round
		write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(1, 8192)));
		write_reg(REG_IMAGE_WIDTH, 16'd1);
		tx_idle = 77;
		rx_idle = 27;
		random_poses(RANDOM_POSES / 3);
		drain();

		// no idling, with a long receiver hold so the input stalls
		write_reg(REG_IMAGE_HEIGHT, 16'd8192);
		write_reg(REG_IMAGE_WIDTH, 16'($urandom_range(1, 8192)));
		tx_idle = 0;
		rx_idle = 0;
		fork
			begin
				@(negedge clk);
				rx_hold <= 1'b1;
				repeat (4000) @(negedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		random_poses(RANDOM_POSES - 2 * (RANDOM_POSES / 3));
		drain();
		repeat (600) @(posedge clk);

		if (errors == 0) begin
			$display("pose_encoding_to_camera_matrices_top regression: pass");
		end else begin
			$display("pose_encoding_to_camera_matrices_top regression: fail");
		end
		$finish;
	end

endmodule
